// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file tspf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/core/tspf_pkg.sv
// Types and constants of the transport stream PID filter.
package tspf_pkg;

   localparam logic [7:0]  SyncByte       = 8'h47;
   localparam logic [4:0]  PidHighMask    = 5'h1f;
   localparam logic [12:0] ResetMatchPid  = 13'h201;
   localparam logic [7:0]  ResetPacketLen = 8'd188;
   localparam logic [7:0]  MinPacketLen   = 8'd3;
   localparam int          QueueDepthDef  = 8;
   localparam int          CsrDataW       = 13;

   // Register indexes of the configuration port.
   localparam logic CsrMatchPid  = 1'b0;
   localparam logic CsrPacketLen = 1'b1;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
   } result_type;

   // Up to three results handed from the parser to the output queue.
   typedef struct packed {
      logic [1:0]      count;
      result_type [2:0] item;
   } push_type;

endpackage

// File: rtl/core/tspf_parser.sv
// Packet framing, PID match and header release for one stream byte.
module tspf_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [7:0]        in_byte,
   input  logic [12:0]       match_pid,
   input  logic [7:0]        packet_length,
   output tspf_pkg::push_type push
);

   typedef enum logic [1:0] {
      ST_SEARCH = 2'b01,
      ST_PACKET = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  held_second_ff, held_second_in;
   logic        forwarding_ff, forwarding_in;

   logic [7:0]  eff_len;
   logic        ends;
   logic [12:0] pid;
   logic        pid_hit;

   always_comb begin
      eff_len = (packet_length < tspf_pkg::MinPacketLen) ? tspf_pkg::MinPacketLen
                                                          : packet_length;
      ends    = ({1'b0, byte_index_ff} + 9'd1) >= {1'b0, eff_len};
      pid     = {held_second_ff[4:0] & tspf_pkg::PidHighMask, in_byte};
      pid_hit = (pid == match_pid);
   end

   always_comb begin
      state_in       = state_ff;
      byte_index_in  = byte_index_ff;
      held_second_in = held_second_ff;
      forwarding_in  = forwarding_ff;
      push.count     = 2'd0;
      push.item[0]   = '{data: in_byte, first: 1'b0, last: ends};
      push.item[1]   = '{data: held_second_ff, first: 1'b0, last: 1'b0};
      push.item[2]   = '{data: in_byte, first: 1'b0, last: ends};
      if (step_en) begin
         case (state_ff)
            ST_SEARCH: begin
               if (in_byte == tspf_pkg::SyncByte) begin
                  state_in      = ST_PACKET;
                  byte_index_in = 8'd1;
               end
            end
            ST_PACKET: begin
               if (byte_index_ff == 8'd1) begin
                  held_second_in = in_byte;
                  byte_index_in  = 8'd2;
               end else begin
                  if (byte_index_ff == 8'd2) begin
                     // Release the held header as three items.
                     forwarding_in = pid_hit;
                     if (pid_hit) begin
                        push.count   = 2'd3;
                        push.item[0] = '{data: tspf_pkg::SyncByte, first: 1'b1, last: 1'b0};
                     end
                  end else if (forwarding_ff) begin
                     push.count = 2'd1;
                  end
                  if (ends) begin
                     state_in      = ST_SEARCH;
                     byte_index_in = 8'd0;
                  end else begin
                     byte_index_in = byte_index_ff + 8'd1;
                  end
               end
            end
            default: begin
               state_in      = ST_SEARCH;
               byte_index_in = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SEARCH;
         byte_index_ff  <= 8'd0;
         held_second_ff <= 8'd0;
         forwarding_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         byte_index_ff  <= byte_index_in;
         held_second_ff <= held_second_in;
         forwarding_ff  <= forwarding_in;
      end
   end

endmodule

// File: rtl/core/tspf_queue.sv
// Small result queue: takes up to three items a cycle, gives one unless rsp_stall holds it.
module tspf_queue #(
   parameter int Depth = tspf_pkg::QueueDepthDef
) (
   input  logic               clock,
   input  logic               reset,
   input  tspf_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tspf_pkg::result_type rsp_item
);

   localparam int PtrW = $clog2(Depth);
   localparam int SumW = PtrW + 1;
   localparam int CntW = $clog2(Depth + 1);

   tspf_pkg::result_type entries [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] slot [3];
   logic            pop;

   always_comb begin
      logic [SumW-1:0] sum;
      logic [SumW-1:0] wsum;
      for (int k = 0; k < 3; k++) begin
         sum = {1'b0, wr_ptr_ff} + SumW'(k);
         if (sum >= SumW'(Depth)) begin
            sum = sum - SumW'(Depth);
         end
         slot[k] = sum[PtrW-1:0];
      end
      wsum = {1'b0, wr_ptr_ff} + SumW'(push.count);
      if (wsum >= SumW'(Depth)) begin
         wsum = wsum - SumW'(Depth);
      end
      wr_ptr_in = wsum[PtrW-1:0];
   end

   always_comb begin
      rsp_valid = (count_ff != '0);
      rsp_item  = entries[rd_ptr_ff];
      pop       = rsp_valid && !rsp_stall;
      room      = (count_ff <= CntW'(Depth - 3));
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(push.count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (push.count > 2'(k)) begin
            entries[slot[k]] <= push.item[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/ts_packet_pid_filter_core.sv
// Transport stream PID filter: one stream byte in per cycle, forwarded bytes out.
// An accepted byte is held in the input register, then written into the output queue.
// Throughput: 1 byte per cycle unless req_stall; a header releases 3 items at once into
// the queue; it drains 1 item per cycle unless rsp_stall, stalls input only if room < 3.
// Reset: synchronous; clears framing state and queue, loads PID 0x201 and length 188.
module ts_packet_pid_filter_core #(
   parameter int QueueDepth = tspf_pkg::QueueDepthDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_packet_first,
   output logic                          rsp_packet_last,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [tspf_pkg::CsrDataW-1:0] csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic [12:0]          match_pid_ff, match_pid_in;
   logic [7:0]           packet_len_ff, packet_len_in;
   logic                 room;
   logic                 advance;
   logic                 accept;
   tspf_pkg::push_type   push;
   tspf_pkg::result_type rsp_item;

   always_comb begin
      advance     = in_valid_ff && room;
      req_stall   = in_valid_ff && !room;
      accept      = req_valid && !req_stall;
      in_valid_in = accept || (in_valid_ff && !advance);
      in_byte_in  = accept ? req_in_byte : in_byte_ff;

      match_pid_in  = match_pid_ff;
      packet_len_in = packet_len_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tspf_pkg::CsrMatchPid:  match_pid_in  = csr_wdata[12:0];
            tspf_pkg::CsrPacketLen: packet_len_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         match_pid_ff  <= tspf_pkg::ResetMatchPid;
         packet_len_ff <= tspf_pkg::ResetPacketLen;
      end else begin
         in_valid_ff   <= in_valid_in;
         match_pid_ff  <= match_pid_in;
         packet_len_ff <= packet_len_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   tspf_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .in_byte       (in_byte_ff),
      .match_pid     (match_pid_ff),
      .packet_length (packet_len_ff),
      .push          (push)
   );

   tspf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_byte     = rsp_item.data;
   assign rsp_packet_first = rsp_item.first;
   assign rsp_packet_last  = rsp_item.last;

endmodule

// File: rtl/core/tspf_checker.sv
// Port-level assertions for the PID filter, bound to the top level.
`include "assert_macros.svh"

module tspf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_packet_first,
   input logic       rsp_packet_last
);

   `ASSERT_CLK_ALWAYS(a_reset_empty, reset |=> (!rsp_valid && !req_stall), "not empty after reset")
   `ASSERT_CLK(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte)), "stalled item changed")
   `ASSERT_CLK(a_first_sync, (rsp_valid && rsp_packet_first) |-> (rsp_out_byte == tspf_pkg::SyncByte), "first item is not sync")
   `ASSERT_CLK(a_first_last, rsp_valid |-> !(rsp_packet_first && rsp_packet_last), "item both first and last")

endmodule

bind ts_packet_pid_filter_core tspf_checker u_tspf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_packet_first (rsp_packet_first),
   .rsp_packet_last  (rsp_packet_last)
);
